@@ rtl/core/dhwm_pkg.sv @@
// Package for the drift hit window multiplicity block.
// Holds shared constants, register indexes and the stage-to-stage hit record.
// No dependencies.
package dhwm_pkg;

  // Default sizes handed to the top level parameters.
  localparam int NUM_LAYERS_DEF  = 9;
  localparam int COUNT_WIDTH_DEF = 16;

  // Window numbering.
  localparam int NUM_WIN  = 3;
  localparam int WIN_GOOD = 0;
  localparam int WIN_OK   = 1;
  localparam int WIN_ANY  = 2;

  // Fixed field widths.
  localparam int TIME_W   = 16;
  localparam int LAYER_W  = 4;
  localparam int MULT_W   = 5;
  localparam int OUT_CNT_W = 16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GOOD_LOW  = 3'd0,
    CFG_GOOD_HIGH = 3'd1,
    CFG_OK_LOW    = 3'd2,
    CFG_OK_HIGH   = 3'd3,
    CFG_ANY_LOW   = 3'd4,
    CFG_ANY_HIGH  = 3'd5,
    CFG_EXCLUDED  = 3'd6
  } cfg_idx_t;

  // Reset values of the configuration registers (0.1 ns units).
  localparam logic [TIME_W-1:0] GOOD_LOW_RST  = 16'sd200;
  localparam logic [TIME_W-1:0] GOOD_HIGH_RST = 16'sd2100;
  localparam logic [TIME_W-1:0] OK_LOW_RST    = 16'sd50;
  localparam logic [TIME_W-1:0] OK_HIGH_RST   = 16'sd2200;
  localparam logic [TIME_W-1:0] ANY_LOW_RST   = -16'sd100;
  localparam logic [TIME_W-1:0] ANY_HIGH_RST  = 16'sd2353;
  localparam logic [15:0]       EXCLUDED_RST  = 16'd544;

  // Classified hit handed from the input stage to the accumulator.
  typedef struct packed {
    logic               counted;  // hit present, layer in range, not masked
    logic               eoe;      // closes the event
    logic [LAYER_W-1:0] layer;
    logic [NUM_WIN-1:0] win;      // window matches, indexed by WIN_*
  } hit_t;

endpackage

@@ rtl/core/dhwm_classify.sv @@
// Input stage: registers one request and classifies it against the windows.
// Depends on dhwm_pkg.
module dhwm_classify #(
  parameter int NUM_LAYERS = dhwm_pkg::NUM_LAYERS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           load,
  input  logic                                           advance,
  input  logic                                           hit_valid,
  input  logic [dhwm_pkg::LAYER_W-1:0]                   layer,
  input  logic [dhwm_pkg::TIME_W-1:0]                    drift_time,
  input  logic                                           end_of_event,
  input  logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::TIME_W-1:0] win_low,
  input  logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::TIME_W-1:0] win_high,
  input  logic [15:0]                                    excluded,
  output logic                                           s1_valid,
  output dhwm_pkg::hit_t                                 s1_hit
);

  logic           valid_r;
  dhwm_pkg::hit_t hit_r;
  dhwm_pkg::hit_t hit_nxt;
  logic signed [dhwm_pkg::TIME_W:0]   t_ext;
  logic        [dhwm_pkg::TIME_W:0]   mag;
  logic signed [dhwm_pkg::TIME_W+1:0] mag_s;
  logic                               layer_ok;

  // Magnitude of the drift time; the most negative value becomes 32768.
  assign t_ext = {drift_time[dhwm_pkg::TIME_W-1], drift_time};
  assign mag   = drift_time[dhwm_pkg::TIME_W-1] ? (dhwm_pkg::TIME_W+1)'(-t_ext)
                                               : (dhwm_pkg::TIME_W+1)'(t_ext);
  assign mag_s = {1'b0, mag};

  assign layer_ok = ({1'b0, layer} < (dhwm_pkg::LAYER_W+1)'(NUM_LAYERS)) &&
                    !excluded[layer];

  // Exclusive window compares and the event flags.
  always_comb begin
    hit_nxt         = '0;
    hit_nxt.counted = hit_valid && layer_ok;
    hit_nxt.eoe     = end_of_event;
    hit_nxt.layer   = layer;
    for (int w = 0; w < dhwm_pkg::NUM_WIN; w++) begin
      hit_nxt.win[w] =
        ($signed({{2{win_low[w][dhwm_pkg::TIME_W-1]}}, win_low[w]}) < mag_s) &&
        (mag_s < $signed({{2{win_high[w][dhwm_pkg::TIME_W-1]}}, win_high[w]}));
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      hit_r <= hit_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_hit   = hit_r;

endmodule

@@ rtl/core/dhwm_accum.sv @@
// Event accumulator: per-layer and total counters plus the result register.
// Depends on dhwm_pkg.
module dhwm_accum #(
  parameter int NUM_LAYERS  = dhwm_pkg::NUM_LAYERS_DEF,
  parameter int COUNT_WIDTH = dhwm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              s1_valid,
  input  dhwm_pkg::hit_t                                    s1_hit,
  output logic                                              advance,
  input  logic                                              out_tready,
  output logic                                              out_valid,
  output logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::MULT_W-1:0]    layers_one,
  output logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::OUT_CNT_W-1:0] hits_win,
  output logic [dhwm_pkg::OUT_CNT_W-1:0]                    hits_total
);

  logic [1:0] cnt_r   [dhwm_pkg::NUM_WIN][NUM_LAYERS];
  logic [1:0] cnt_nxt [dhwm_pkg::NUM_WIN][NUM_LAYERS];
  logic [COUNT_WIDTH-1:0] tot_r   [dhwm_pkg::NUM_WIN];
  logic [COUNT_WIDTH-1:0] tot_nxt [dhwm_pkg::NUM_WIN];
  logic [COUNT_WIDTH-1:0] all_r;
  logic [COUNT_WIDTH-1:0] all_nxt;
  logic [dhwm_pkg::MULT_W-1:0] one_nxt [dhwm_pkg::NUM_WIN];
  logic [31:0] tot_wide [dhwm_pkg::NUM_WIN];
  logic [31:0] all_wide;
  logic        out_valid_r;
  logic        close;

  // An event close needs the result register free; plain hits always move.
  assign advance = s1_valid && (!s1_hit.eoe || !out_valid_r || out_tready);
  assign close   = advance && s1_hit.eoe;

  // Next counter values including the hit in the stage register.
  always_comb begin
    for (int w = 0; w < dhwm_pkg::NUM_WIN; w++) begin
      one_nxt[w] = '0;
      for (int l = 0; l < NUM_LAYERS; l++) begin
        if (s1_hit.counted && s1_hit.win[w] &&
            s1_hit.layer == dhwm_pkg::LAYER_W'(l) && cnt_r[w][l] != 2'd3) begin
          cnt_nxt[w][l] = cnt_r[w][l] + 2'd1;
        end else begin
          cnt_nxt[w][l] = cnt_r[w][l];
        end
        if (cnt_nxt[w][l] == 2'd1) begin
          one_nxt[w] = one_nxt[w] + dhwm_pkg::MULT_W'(1);
        end
      end
      if (s1_hit.counted && s1_hit.win[w] && tot_r[w] != '1) begin
        tot_nxt[w] = tot_r[w] + COUNT_WIDTH'(1);
      end else begin
        tot_nxt[w] = tot_r[w];
      end
      tot_wide[w] = 32'(tot_nxt[w]);
    end
    if (s1_hit.counted && all_r != '1) begin
      all_nxt = all_r + COUNT_WIDTH'(1);
    end else begin
      all_nxt = all_r;
    end
    all_wide = 32'(all_nxt);
  end

  // Counter state: updated per hit, cleared when the event closes.
  always_ff @(posedge clk) begin
    if (!rst_n || close) begin
      for (int w = 0; w < dhwm_pkg::NUM_WIN; w++) begin
        for (int l = 0; l < NUM_LAYERS; l++) begin
          cnt_r[w][l] <= 2'd0;
        end
        tot_r[w] <= '0;
      end
      all_r <= '0;
    end else if (advance) begin
      for (int w = 0; w < dhwm_pkg::NUM_WIN; w++) begin
        for (int l = 0; l < NUM_LAYERS; l++) begin
          cnt_r[w][l] <= cnt_nxt[w][l];
        end
        tot_r[w] <= tot_nxt[w];
      end
      all_r <= all_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (close) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (close) begin
      for (int w = 0; w < dhwm_pkg::NUM_WIN; w++) begin
        layers_one[w] <= one_nxt[w];
        hits_win[w]   <= tot_wide[w][dhwm_pkg::OUT_CNT_W-1:0];
      end
      hits_total <= all_wide[dhwm_pkg::OUT_CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/drift_hit_window_multiplicity.sv @@
// Top level of the drift hit window multiplicity block.
// Depends on dhwm_pkg, dhwm_classify and dhwm_accum.
//
// Takes one hit request per clock cycle and emits one result per event, once
// the tlast request has passed the input register and the result register.
// The input register holds the window compares and the accumulator folds
// each hit into the per-layer and total counters as it leaves that register.
// A result still waiting in the output register holds the next tlast request
// in the input register, and the input stalls behind it; plain hits ahead of
// that request keep flowing. Configuration writes are taken every cycle
// (cfg_ready is always high) and must only be made while no event is in flight.
module drift_hit_window_multiplicity #(
  parameter int NUM_LAYERS  = dhwm_pkg::NUM_LAYERS_DEF,
  parameter int COUNT_WIDTH = dhwm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Hit requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] layer, [19:4] drift_time, [23:20] zero
  input  logic        in_tuser,   // [0] hit_valid
  input  logic        in_tlast,   // end_of_event
  // Event results.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] layers_one_good, [9:5] layers_one_ok, [14:10] layers_one_any,
  // [30:15] hits_good, [46:31] hits_ok, [62:47] hits_any,
  // [78:63] hits_total, [79] zero
  output logic [79:0] out_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::TIME_W-1:0] win_low_r;
  logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::TIME_W-1:0] win_high_r;
  logic [15:0]    excluded_r;
  logic           load;
  logic           advance;
  logic           s1_valid;
  dhwm_pkg::hit_t s1_hit;
  logic           out_valid;
  logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::MULT_W-1:0]    layers_one;
  logic [dhwm_pkg::NUM_WIN-1:0][dhwm_pkg::OUT_CNT_W-1:0] hits_win;
  logic [dhwm_pkg::OUT_CNT_W-1:0] hits_total;

  // Configuration register file.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r[dhwm_pkg::WIN_GOOD]  <= dhwm_pkg::GOOD_LOW_RST;
      win_high_r[dhwm_pkg::WIN_GOOD] <= dhwm_pkg::GOOD_HIGH_RST;
      win_low_r[dhwm_pkg::WIN_OK]    <= dhwm_pkg::OK_LOW_RST;
      win_high_r[dhwm_pkg::WIN_OK]   <= dhwm_pkg::OK_HIGH_RST;
      win_low_r[dhwm_pkg::WIN_ANY]   <= dhwm_pkg::ANY_LOW_RST;
      win_high_r[dhwm_pkg::WIN_ANY]  <= dhwm_pkg::ANY_HIGH_RST;
      excluded_r                     <= dhwm_pkg::EXCLUDED_RST;
    end else if (cfg_valid) begin
      unique case (dhwm_pkg::cfg_idx_t'(cfg_index))
        dhwm_pkg::CFG_GOOD_LOW:  win_low_r[dhwm_pkg::WIN_GOOD]  <= cfg_data;
        dhwm_pkg::CFG_GOOD_HIGH: win_high_r[dhwm_pkg::WIN_GOOD] <= cfg_data;
        dhwm_pkg::CFG_OK_LOW:    win_low_r[dhwm_pkg::WIN_OK]    <= cfg_data;
        dhwm_pkg::CFG_OK_HIGH:   win_high_r[dhwm_pkg::WIN_OK]   <= cfg_data;
        dhwm_pkg::CFG_ANY_LOW:   win_low_r[dhwm_pkg::WIN_ANY]   <= cfg_data;
        dhwm_pkg::CFG_ANY_HIGH:  win_high_r[dhwm_pkg::WIN_ANY]  <= cfg_data;
        dhwm_pkg::CFG_EXCLUDED:  excluded_r                     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register is free when empty or when its hit moves on.
  assign in_tready = !s1_valid || advance;
  assign load      = in_tvalid && in_tready;

  dhwm_classify #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_classify (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .advance      (advance),
    .hit_valid    (in_tuser),
    .layer        (in_tdata[3:0]),
    .drift_time   (in_tdata[19:4]),
    .end_of_event (in_tlast),
    .win_low      (win_low_r),
    .win_high     (win_high_r),
    .excluded     (excluded_r),
    .s1_valid     (s1_valid),
    .s1_hit       (s1_hit)
  );

  dhwm_accum #(
    .NUM_LAYERS  (NUM_LAYERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_hit     (s1_hit),
    .advance    (advance),
    .out_tready (out_tready),
    .out_valid  (out_valid),
    .layers_one (layers_one),
    .hits_win   (hits_win),
    .hits_total (hits_total)
  );

  // Result packing.
  assign out_tvalid = out_valid;
  assign out_tdata  = {1'b0, hits_total,
                       hits_win[dhwm_pkg::WIN_ANY], hits_win[dhwm_pkg::WIN_OK],
                       hits_win[dhwm_pkg::WIN_GOOD],
                       layers_one[dhwm_pkg::WIN_ANY], layers_one[dhwm_pkg::WIN_OK],
                       layers_one[dhwm_pkg::WIN_GOOD]};

endmodule

@@ rtl/core/dhwm_checker.sv @@
// Port-level checks for the drift hit window multiplicity block, with bind.
// Depends on drift_hit_window_multiplicity.
module dhwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every window hit is also a counted hit.
  a_win_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:15] <= out_tdata[78:63] &&
                   out_tdata[46:31] <= out_tdata[78:63] &&
                   out_tdata[62:47] <= out_tdata[78:63])
    else $error("window total above hit total");

  // A layer with exactly one window hit contributes that hit to the total.
  a_mult_le_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 16'(out_tdata[4:0]) <= out_tdata[30:15] &&
                   16'(out_tdata[9:5]) <= out_tdata[46:31] &&
                   16'(out_tdata[14:10]) <= out_tdata[62:47])
    else $error("single-hit layer count above window total");

  // No result straight out of reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind drift_hit_window_multiplicity dhwm_checker u_dhwm_checker (.*);
